### src/lppr_pkg.sv
`timescale 1ns / 1ps

package lppr_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = 11;
    localparam int HGT_W     = 16;
    localparam int SEL_W     = 4;
    localparam int CFG_W     = 16;
    localparam int IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_PRED_SEL = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH    = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT   = 2'd2;

    localparam logic [SEL_W-1:0] PRED_W    = 4'd1;
    localparam logic [SEL_W-1:0] PRED_N    = 4'd2;
    localparam logic [SEL_W-1:0] PRED_NW   = 4'd3;
    localparam logic [SEL_W-1:0] PRED_GRAD = 4'd4;
    localparam logic [SEL_W-1:0] PRED_NHW  = 4'd5;
    localparam logic [SEL_W-1:0] PRED_WHN  = 4'd6;
    localparam logic [SEL_W-1:0] PRED_AVG  = 4'd7;
    localparam logic [SEL_W-1:0] PRED_MED  = 4'd8;

    localparam logic [SEL_W-1:0] RST_PRED_SEL = PRED_MED;
    localparam logic [WID_W-1:0] RST_WIDTH    = 11'd1024;
    localparam logic [HGT_W-1:0] RST_HEIGHT   = 16'd1024;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        pixel_t cur;
        pixel_t n;
        pixel_t w;
        pixel_t nw;
    } nbr_t;

    typedef struct packed {
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] height;
    } geom_t;

    function automatic logic [7:0] residual(input logic [7:0] cur, input logic [7:0] nw,
                                            input logic [7:0] n, input logic [7:0] w,
                                            input logic [SEL_W-1:0] sel);
        logic signed [9:0] sw;
        logic signed [9:0] sn;
        logic signed [9:0] snw;
        logic signed [9:0] dw;
        logic signed [9:0] dn;
        logic signed [9:0] tw;
        logic signed [9:0] tn;
        logic signed [9:0] hw;
        logic signed [9:0] hn;
        logic signed [9:0] grad;
        logic [8:0]        sum;
        logic [7:0]        mx;
        logic [7:0]        mn;
        logic [7:0]        p;
        sw   = signed'({2'b00, w});
        sn   = signed'({2'b00, n});
        snw  = signed'({2'b00, nw});
        dw   = sw - snw;
        dn   = sn - snw;
        tw   = dw + signed'({9'd0, dw[9]});
        tn   = dn + signed'({9'd0, dn[9]});
        hw   = tw >>> 1;
        hn   = tn >>> 1;
        grad = sn + sw - snw;
        sum  = {1'b0, n} + {1'b0, w};
        mx   = (w >= n) ? w : n;
        mn   = (w <= n) ? w : n;
        case (sel)
            PRED_W:    p = w;
            PRED_N:    p = n;
            PRED_NW:   p = nw;
            PRED_GRAD: p = grad[7:0];
            PRED_NHW:  p = n + hw[7:0];
            PRED_WHN:  p = w + hn[7:0];
            PRED_AVG:  p = sum[8:1];
            PRED_MED:
            begin
                if (nw >= mx)
                begin
                    p = mn;
                end
                else if (nw <= mn)
                begin
                    p = mx;
                end
                else
                begin
                    p = grad[7:0];
                end
            end
            default:   p = 8'hFF;
        endcase
        return cur - p;
    endfunction

endpackage

### src/lppr_front.sv
`timescale 1ns / 1ps

module lppr_front
    import lppr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  geom_t  geom,
    input  logic   push,
    output logic   full,
    input  pixel_t pix,
    output logic   q_push,
    input  logic   q_ready,
    output nbr_t   q_data
);

    pixel_t             line_mem [MAX_WIDTH];
    pixel_t             rd_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [HGT_W-1:0]   row_reg;
    logic [HGT_W-1:0]   row_next;
    pixel_t             west_reg;
    pixel_t             nw_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    pixel_t             s1_cur_reg;
    pixel_t             s1_west_reg;
    logic               s1_colz_reg;
    logic               s1_rowz_reg;
    logic               accept;
    logic               advance;
    logic [WID_W-1:0]   wid_eff;
    logic [HGT_W-1:0]   hgt_eff;
    logic [WID_W-1:0]   col_inc;
    logic [HGT_W:0]     row_inc;

    assign advance = s1_valid_reg && q_ready;
    assign full    = s1_valid_reg && !q_ready;
    assign accept  = push && !full;

    always_comb
    begin
        if (geom.width == '0)
        begin
            wid_eff = WID_W'(1);
        end
        else if (geom.width > WID_W'(MAX_WIDTH))
        begin
            wid_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            wid_eff = geom.width;
        end
        hgt_eff = (geom.height == '0) ? HGT_W'(1) : geom.height;
        col_inc = {{(WID_W-COL_W){1'b0}}, col_reg} + WID_W'(1);
        row_inc = {1'b0, row_reg} + (HGT_W+1)'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= wid_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= {1'b0, hgt_eff}) ? '0 : row_inc[HGT_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg            <= line_mem[col_reg];
            line_mem[col_reg] <= pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cur_reg  <= pix;
            s1_west_reg <= west_reg;
            s1_colz_reg <= (col_reg == '0);
            s1_rowz_reg <= (row_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            west_reg     <= '0;
            nw_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                west_reg <= pix;
            end
            if (advance)
            begin
                nw_reg <= rd_reg;
            end
        end
    end

    assign q_push    = advance;
    assign q_data.cur = s1_cur_reg;
    assign q_data.n   = s1_rowz_reg ? '0 : rd_reg;
    assign q_data.w   = s1_colz_reg ? '0 : s1_west_reg;
    assign q_data.nw  = (s1_colz_reg || s1_rowz_reg) ? '0 : nw_reg;

endmodule

### src/lppr_queue.sv
`timescale 1ns / 1ps

module lppr_queue
    import lppr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic ready,
    input  nbr_t wr_data,
    output logic valid,
    input  logic pop,
    output nbr_t rd_data
);

    nbr_t       data_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign ready   = (count_reg != 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign do_push = push && ready;
    assign do_pop  = pop && valid;
    assign rd_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

### src/lppr_back.sv
`timescale 1ns / 1ps

module lppr_back
    import lppr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [SEL_W-1:0] pred_sel,
    input  logic             q_valid,
    output logic             q_pop,
    input  nbr_t             q_data,
    output logic             empty,
    input  logic             pop,
    output pixel_t           res
);

    pixel_t     out_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;
    pixel_t     calc;

    always_comb
    begin
        calc.red   = residual(q_data.cur.red, q_data.nw.red, q_data.n.red,
                              q_data.w.red, pred_sel);
        calc.green = residual(q_data.cur.green, q_data.nw.green, q_data.n.green,
                              q_data.w.green, pred_sel);
        calc.blue  = residual(q_data.cur.blue, q_data.nw.blue, q_data.n.blue,
                              q_data.w.blue, pred_sel);
    end

    assign do_push = q_valid && (count_reg != 2'd2);
    assign q_pop   = do_push;
    assign empty   = (count_reg == 2'd0);
    assign do_pop  = pop && !empty;
    assign res     = out_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            out_reg[wr_ptr_reg] <= calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

### src/lossless_pixel_predictor_residual.sv
// Path: a pixel accepted into the front stage registers passes through the two-entry queue
// and the two-entry result buffer before it shows on the result ports.
// Throughput: one pixel per cycle while results are popped and full stays low, set by the
// line buffer, which takes one read and one write per accepted pixel on a single port.
// Reset: registers return to MED, width 1024, height 1024; counters and neighbors clear;
// the line buffer is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module lossless_pixel_predictor_residual
    import lppr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       red_in,
    input  logic [7:0]       green_in,
    input  logic [7:0]       blue_in,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       red_residual,
    output logic [7:0]       green_residual,
    output logic [7:0]       blue_residual,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [SEL_W-1:0] pred_sel_reg;
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    geom_t            geom;
    pixel_t           pix;
    pixel_t           res;
    nbr_t             f_data;
    nbr_t             b_data;
    logic             f_push;
    logic             f_ready;
    logic             b_valid;
    logic             b_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_sel_reg <= RST_PRED_SEL;
            width_reg    <= RST_WIDTH;
            height_reg   <= RST_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PRED_SEL: pred_sel_reg <= cfg_data[SEL_W-1:0];
                REG_WIDTH:    width_reg    <= cfg_data[WID_W-1:0];
                REG_HEIGHT:   height_reg   <= cfg_data[HGT_W-1:0];
                default:      ;
            endcase
        end
    end

    assign geom.width  = width_reg;
    assign geom.height = height_reg;
    assign pix.red     = red_in;
    assign pix.green   = green_in;
    assign pix.blue    = blue_in;

    lppr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .geom    (geom),
        .push    (push),
        .full    (full),
        .pix     (pix),
        .q_push  (f_push),
        .q_ready (f_ready),
        .q_data  (f_data)
    );

    lppr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (f_push),
        .ready   (f_ready),
        .wr_data (f_data),
        .valid   (b_valid),
        .pop     (b_pop),
        .rd_data (b_data)
    );

    lppr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pred_sel (pred_sel_reg),
        .q_valid  (b_valid),
        .q_pop    (b_pop),
        .q_data   (b_data),
        .empty    (empty),
        .pop      (pop),
        .res      (res)
    );

    assign red_residual   = res.red;
    assign green_residual = res.green;
    assign blue_residual  = res.blue;

endmodule
